@@ sv/rec_pkg.sv @@
`timescale 1ns / 1ps

package rec_pkg;

  // Datapath widths and coder constants
  localparam int PEND_BITS    = 32;   // width of the held-back byte count
  localparam int FILL_W       = 32;   // width of fill_count
  localparam int PC_W         = 4;    // micro-program counter width
  localparam int LOW_W        = 33;   // low end plus carry bit
  localparam int PROB_SHIFT   = 14;   // bit probabilities are in 1/16384 units
  localparam int FLUSH_SHIFTS = 5;
  localparam int DIV_STEPS    = 16;   // two quotient bits per step, 32 bits

  localparam logic [31:0] TOP_VALUE  = 32'h0100_0000;
  localparam logic [31:0] EMIT_LIMIT = 32'hFF00_0000;
  localparam logic [7:0]  FILL_NO_CARRY = 8'hFF;
  localparam logic [7:0]  FILL_CARRY    = 8'h00;
  localparam logic [FILL_W-1:0] FILL_MAX = {FILL_W{1'b1}};

  // Opcodes
  localparam logic [2:0] OP_INTERVAL = 3'd0;
  localparam logic [2:0] OP_BIT_ZERO = 3'd1;
  localparam logic [2:0] OP_BIT_ONE  = 3'd2;
  localparam logic [2:0] OP_FLUSH    = 3'd3;
  localparam logic [2:0] OP_RESTART  = 3'd4;

  // Transaction payloads
  typedef struct packed {
    logic [2:0]  opcode;
    logic [15:0] start_req;
    logic [15:0] size;
    logic [15:0] total;
  } rec_in_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic [7:0]        fill_byte;
    logic [FILL_W-1:0] fill_count;
    logic              last;
  } rec_out_t;

  // Micro-program addresses
  typedef logic [PC_W-1:0] upc_t;

  localparam upc_t S_IDLE      = 4'd0;
  localparam upc_t S_DIV_INIT  = 4'd1;
  localparam upc_t S_DIV_STEP  = 4'd2;
  localparam upc_t S_MUL_START = 4'd3;
  localparam upc_t S_ADD_SIZE  = 4'd4;
  localparam upc_t S_SET_RANGE = 4'd5;
  localparam upc_t S_BIT_ZERO  = 4'd6;
  localparam upc_t S_BIT_ONE   = 4'd7;
  localparam upc_t S_ONE_UPD   = 4'd8;
  localparam upc_t S_NORM      = 4'd9;
  localparam upc_t S_FLUSH     = 4'd10;
  localparam upc_t S_FLUSH_SH  = 4'd11;
  localparam upc_t S_RESTART   = 4'd12;
  localparam upc_t S_FIN       = 4'd13;

  // Sequencing conditions
  typedef enum logic [2:0] {
    C_NEXT,     // fall through
    C_JUMP,     // always jump to target
    C_WAIT,     // wait for a transaction, then dispatch on opcode
    C_TOTALZ,   // jump to target if total is zero
    C_CNT,      // stay and count down, jump to target at zero
    C_NORM      // stay while range is below the top, then jump to target
  } cond_t;

  typedef enum logic [1:0] {
    M_NONE,
    M_Q_START,  // quotient * start_req
    M_Q_SIZE,   // quotient * size
    M_R_SIZE    // (range >> 14) * size
  } mul_sel_t;

  typedef enum logic [1:0] {
    R_NONE,
    R_PROD,     // range = product
    R_DIFF      // range = range - product
  } range_src_t;

  typedef struct packed {
    cond_t      cond;
    upc_t       tgt;
    mul_sel_t   mul_sel;
    logic       low_add;
    range_src_t range_src;
    logic       div_init;
    logic       div_step;
    logic       shift;
    logic       cnt_ld;
    logic [3:0] cnt_val;
    logic       restart;
    logic       fin;
  } ucode_t;

  // Control store
  function automatic ucode_t ucode_rom(upc_t pc);
    ucode_t w;
    w           = '0;
    w.cond      = C_NEXT;
    w.tgt       = S_IDLE;
    w.mul_sel   = M_NONE;
    w.range_src = R_NONE;
    unique case (pc)
      S_IDLE: begin
        w.cond = C_WAIT;
      end
      S_DIV_INIT: begin
        w.div_init = 1'b1;
        w.cnt_ld   = 1'b1;
        w.cnt_val  = 4'(DIV_STEPS - 1);
        w.cond     = C_TOTALZ;
        w.tgt      = S_FIN;
      end
      S_DIV_STEP: begin
        w.div_step = 1'b1;
        w.cond     = C_CNT;
        w.tgt      = S_MUL_START;
      end
      S_MUL_START: begin
        w.mul_sel = M_Q_START;
      end
      S_ADD_SIZE: begin
        w.low_add = 1'b1;
        w.mul_sel = M_Q_SIZE;
      end
      S_SET_RANGE: begin
        w.range_src = R_PROD;
        w.cond      = C_JUMP;
        w.tgt       = S_NORM;
      end
      S_BIT_ZERO: begin
        w.mul_sel = M_R_SIZE;
        w.cond    = C_JUMP;
        w.tgt     = S_SET_RANGE;
      end
      S_BIT_ONE: begin
        w.mul_sel = M_R_SIZE;
      end
      S_ONE_UPD: begin
        w.low_add   = 1'b1;
        w.range_src = R_DIFF;
        w.cond      = C_JUMP;
        w.tgt       = S_NORM;
      end
      S_NORM: begin
        w.shift = 1'b1;
        w.cond  = C_NORM;
        w.tgt   = S_FIN;
      end
      S_FLUSH: begin
        w.cnt_ld  = 1'b1;
        w.cnt_val = 4'(FLUSH_SHIFTS - 1);
      end
      S_FLUSH_SH: begin
        w.shift = 1'b1;
        w.cond  = C_CNT;
        w.tgt   = S_FIN;
      end
      S_RESTART: begin
        w.restart = 1'b1;
        w.cond    = C_JUMP;
        w.tgt     = S_FIN;
      end
      S_FIN: begin
        w.fin  = 1'b1;
        w.cond = C_JUMP;
        w.tgt  = S_IDLE;
      end
      default: begin
        w.cond = C_JUMP;
        w.tgt  = S_IDLE;
      end
    endcase
    return w;
  endfunction

  // Dispatch table: opcode to program entry
  function automatic upc_t entry_of(logic [2:0] opcode);
    upc_t e;
    unique case (opcode)
      OP_INTERVAL: e = S_DIV_INIT;
      OP_BIT_ZERO: e = S_BIT_ZERO;
      OP_BIT_ONE:  e = S_BIT_ONE;
      OP_FLUSH:    e = S_FLUSH;
      OP_RESTART:  e = S_RESTART;
      default:     e = S_FIN;      // undefined opcodes do nothing
    endcase
    return e;
  endfunction

endpackage

@@ sv/range_encoder_with_carry_cache_unit.sv @@
`timescale 1ns / 1ps

// Byte-output range encoder with a carry cache. Each input transaction codes
// an interval (start/size/total), a binary zero or one with a 14-bit
// probability, flushes the coder with five low shifts, or restarts it. Every
// low shift that releases the held-back bytes yields one output transaction:
// the cached byte plus carry, followed by fill_count bytes of fill_byte; last
// marks the final output of an input transaction. One transaction is worked
// at a time by a micro-programmed sequencer around one 32x16 multiplier and a
// radix-4 divider. An interval item runs accept, divider setup, 16 divider
// steps, three multiply/update steps, byte shifts plus a range check and a
// closing step; bit items a multiply, an update, the shifts and closing step;
// a flush a load, five shifts and a closing step; a restart a reset and a
// closing step. A step that passes a result on waits while the output stalls.
module range_encoder_with_carry_cache_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  rec_pkg::rec_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output rec_pkg::rec_out_t out_data
);
  import rec_pkg::*;

  localparam int EXT_W = PEND_BITS + FILL_W;

  // Sequencer
  upc_t       pc_r, pc_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  ucode_t     cw;

  // Coder state
  logic [LOW_W-1:0]     low_r, low_nxt;
  logic [31:0]          range_r, range_nxt;
  logic [7:0]           cache_r, cache_nxt;
  logic [PEND_BITS-1:0] pend_r, pend_nxt;

  // Datapath registers
  rec_in_t     in_r, in_nxt;
  logic [31:0] dq_r, dq_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [31:0] prod_r, prod_nxt;
  rec_out_t    hold_r, hold_nxt;
  logic        hold_valid_r, hold_valid_nxt;
  rec_out_t    out_r, out_nxt;
  logic        out_valid_r, out_valid_nxt;

  // Combinational helpers
  logic [16:0]          t1, t2;
  logic [15:0]          r1, r2;
  logic                 b1, b2;
  logic [31:0]          mul_a;
  logic [15:0]          mul_b;
  logic [47:0]          prod_full;
  logic [31:0]          range_new;
  logic                 range_ge_top;
  logic                 carry;
  logic                 emit;
  logic                 shift_act;
  logic                 need_push;
  logic                 out_free;
  logic                 go;
  logic [PEND_BITS-1:0] pend_m1;
  logic [EXT_W-1:0]     pend_ext;
  rec_out_t             new_res;

  assign cw = ucode_rom(pc_r);

  // Radix-4 restoring divider: two quotient bits per step
  always_comb begin
    t1 = {rem_r, dq_r[31]};
    b1 = (t1 >= {1'b0, in_r.total});
    r1 = b1 ? 16'(t1 - {1'b0, in_r.total}) : t1[15:0];
    t2 = {r1, dq_r[30]};
    b2 = (t2 >= {1'b0, in_r.total});
    r2 = b2 ? 16'(t2 - {1'b0, in_r.total}) : t2[15:0];
  end

  // Shared multiplier, product registered
  always_comb begin
    mul_a = (cw.mul_sel == M_R_SIZE) ? {{PROB_SHIFT{1'b0}}, range_r[31:PROB_SHIFT]}
                                     : dq_r;
    mul_b = (cw.mul_sel == M_Q_START) ? in_r.start_req : in_r.size;
    prod_full = mul_a * mul_b;
  end

  // Range update source, a collapsed range becomes one
  always_comb begin
    range_new = (cw.range_src == R_DIFF) ? (range_r - prod_r) : prod_r;
    if (range_new == 32'd0) begin
      range_new = 32'd1;
    end
  end

  // Low shift decision and the released result
  always_comb begin
    carry        = low_r[LOW_W-1];
    emit         = carry || (low_r[31:0] < EMIT_LIMIT);
    range_ge_top = (range_r >= TOP_VALUE);
    shift_act    = cw.shift && !((cw.cond == C_NORM) && range_ge_top);
    pend_m1      = pend_r - PEND_BITS'(1);
    pend_ext     = EXT_W'(pend_m1);
    new_res.out_byte   = cache_r + {7'd0, carry};
    new_res.fill_byte  = carry ? FILL_CARRY : FILL_NO_CARRY;
    new_res.fill_count = (pend_ext > EXT_W'(FILL_MAX)) ? FILL_MAX
                                                       : pend_ext[FILL_W-1:0];
    new_res.last       = 1'b0;
  end

  // Step stalls when the held result must move out and the output is full
  assign out_free  = !out_valid_r || !out_stall;
  assign need_push = hold_valid_r && ((shift_act && emit) || cw.fin);
  assign go        = !(need_push && !out_free);

  // Next-state logic
  always_comb begin
    pc_nxt         = pc_r;
    cnt_nxt        = cnt_r;
    low_nxt        = low_r;
    range_nxt      = range_r;
    cache_nxt      = cache_r;
    pend_nxt       = pend_r;
    in_nxt         = in_r;
    dq_nxt         = dq_r;
    rem_nxt        = rem_r;
    prod_nxt       = prod_r;
    hold_nxt       = hold_r;
    hold_valid_nxt = hold_valid_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && out_stall;

    if (go) begin
      // sequencing
      unique case (cw.cond)
        C_NEXT:   pc_nxt = pc_r + 4'd1;
        C_JUMP:   pc_nxt = cw.tgt;
        C_WAIT: begin
          if (in_valid) begin
            pc_nxt = entry_of(in_data.opcode);
            in_nxt = in_data;
          end
        end
        C_TOTALZ: pc_nxt = (in_r.total == 16'd0) ? cw.tgt : pc_r + 4'd1;
        C_CNT: begin
          if (cnt_r == 4'd0) begin
            pc_nxt = cw.tgt;
          end else begin
            cnt_nxt = cnt_r - 4'd1;
          end
        end
        C_NORM: begin
          if (range_ge_top) begin
            pc_nxt = cw.tgt;
          end
        end
        default: pc_nxt = S_IDLE;
      endcase

      if (cw.cnt_ld) begin
        cnt_nxt = cw.cnt_val;
      end

      // divider
      if (cw.div_init) begin
        dq_nxt  = range_r;
        rem_nxt = 16'd0;
      end else if (cw.div_step) begin
        dq_nxt  = {dq_r[29:0], b1, b2};
        rem_nxt = r2;
      end

      // multiplier
      if (cw.mul_sel != M_NONE) begin
        prod_nxt = prod_full[31:0];
      end

      if (cw.low_add) begin
        low_nxt = low_r + {1'b0, prod_r};
      end

      if (cw.range_src != R_NONE) begin
        range_nxt = range_new;
      end

      // byte shift of low; range moves along only while normalizing
      if (shift_act) begin
        if (cw.cond == C_NORM) begin
          range_nxt = {range_r[23:0], 8'h00};
        end
        low_nxt   = {1'b0, low_r[23:0], 8'h00};
        if (emit) begin
          cache_nxt      = low_r[31:24];
          pend_nxt       = PEND_BITS'(1);
          hold_nxt       = new_res;
          hold_valid_nxt = 1'b1;
        end else if (pend_r != {PEND_BITS{1'b1}}) begin
          pend_nxt = pend_r + PEND_BITS'(1);
        end
      end

      if (cw.fin) begin
        hold_valid_nxt = 1'b0;
      end

      // previous result leaves; it is the last one at the closing step
      if (need_push) begin
        out_nxt       = hold_r;
        out_nxt.last  = cw.fin;
        out_valid_nxt = 1'b1;
      end

      if (cw.restart) begin
        low_nxt   = '0;
        range_nxt = '1;
        cache_nxt = '0;
        pend_nxt  = PEND_BITS'(1);
      end
    end
  end

  // Control and coder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r         <= S_IDLE;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      low_r        <= '0;
      range_r      <= '1;
      cache_r      <= '0;
      pend_r       <= PEND_BITS'(1);
    end else begin
      pc_r         <= pc_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      low_r        <= low_nxt;
      range_r      <= range_nxt;
      cache_r      <= cache_nxt;
      pend_r       <= pend_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    in_r   <= in_nxt;
    dq_r   <= dq_nxt;
    rem_r  <= rem_nxt;
    prod_r <= prod_nxt;
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

  assign in_stall  = (pc_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
